[src/tmtw_pkg.sv]
// tmtw_pkg: shared types, constants and helpers for the text mode terminal writer
// screen geometry, transfer payload structs, command codes and back-end states
// no dependencies
package tmtw_pkg;

  localparam int COLUMNS   = 80;
  localparam int ROWS      = 25;
  localparam int CELLS     = COLUMNS * ROWS;
  localparam int ADDR_W    = $clog2(CELLS);
  localparam int COL_W     = 7;
  localparam int ROW_W     = 5;
  localparam int CELL_W    = 16;
  localparam int Q_DEPTH   = 2;
  localparam int Q_PTR_W   = 1;
  localparam int Q_CNT_W   = 2;

  localparam logic [7:0]        NEWLINE_CODE     = 8'd10;
  localparam logic [CELL_W-1:0] BLANK_CELL       = 16'h0720;
  localparam logic [7:0]        TEXT_COLOR_RESET = 8'd7;

  typedef logic [ADDR_W-1:0] addr_t;

  typedef enum logic [1:0] {
    OP_PUT_CHAR  = 2'd0,
    OP_PUT_CELL  = 2'd1,
    OP_READ_CELL = 2'd2,
    OP_NONE      = 2'd3
  } op_e;

  typedef struct packed {
    op_e              operation;
    logic [7:0]       char_code;
    logic [7:0]       put_color;
    logic [COL_W-1:0] pos_x;
    logic [ROW_W-1:0] pos_y;
  } in_item_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_value;
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_column;
  } out_item_t;

  typedef enum logic [2:0] {
    CMD_CHAR,
    CMD_NEWLINE,
    CMD_PUT,
    CMD_READ,
    CMD_NOP
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e         kind;
    logic [CELL_W-1:0] cell_data;
    addr_t             addr;
  } cmd_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } bk_ctl_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_SCROLL,
    ST_ZERO,
    ST_READ
  } state_e;

  function automatic addr_t cell_addr(logic [ROW_W-1:0] row, logic [COL_W-1:0] col);
    cell_addr = ADDR_W'(int'(row) * COLUMNS + int'(col));
  endfunction

endpackage

[src/tmtw_front.sv]
// tmtw_front: accepts input transfers, classifies them into commands and queues them
// depends on tmtw_pkg
module tmtw_front import tmtw_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_data_i,
  input  bk_ctl_t  bk_i,
  output logic     cmd_valid_o,
  output cmd_t     cmd_o
);

  cmd_t                 cmd_d;
  logic                 on_screen;
  logic                 push;
  logic                 pop;
  cmd_t                 fifo_q [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [Q_PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [Q_CNT_W-1:0]   cnt_q, cnt_d;

  always_comb begin
    on_screen = (in_data_i.pos_x < COL_W'(COLUMNS)) && (in_data_i.pos_y < ROW_W'(ROWS));
    cmd_d.cell_data = {in_data_i.put_color, in_data_i.char_code};
    cmd_d.addr = cell_addr(in_data_i.pos_y, in_data_i.pos_x);
    unique case (in_data_i.operation)
      OP_PUT_CHAR:  cmd_d.kind = (in_data_i.char_code == NEWLINE_CODE) ? CMD_NEWLINE : CMD_CHAR;
      OP_PUT_CELL:  cmd_d.kind = on_screen ? CMD_PUT : CMD_NOP;
      OP_READ_CELL: cmd_d.kind = on_screen ? CMD_READ : CMD_NOP;
      default:      cmd_d.kind = CMD_NOP;
    endcase
  end

  assign in_stall_o  = (cnt_q == Q_CNT_W'(Q_DEPTH)) || bk_i.clearing;
  assign push        = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (cnt_q != '0);
  assign pop         = bk_i.pop && cmd_valid_o;
  assign cmd_o       = fifo_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cmd_d;
    end
  end

endmodule

[src/tmtw_back.sv]
// tmtw_back: executes queued commands against the cell store and holds the cursor
// owns the screen memory, clear and scroll sequencer, color register and output register
// depends on tmtw_pkg
module tmtw_back import tmtw_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  input  cmd_t      cmd_i,
  output bk_ctl_t   bk_o,
  input  logic      cfg_we_i,
  input  logic [7:0] cfg_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  localparam addr_t LAST_ADDR = ADDR_W'(CELLS - 1);
  localparam addr_t MOVE_END  = ADDR_W'((ROWS - 1) * COLUMNS);

  state_e             state_q, state_d;
  addr_t              cnt_q, cnt_d;
  cmd_t               cur_q, cur_d;
  logic [ROW_W-1:0]   row_q, row_d;
  logic [COL_W-1:0]   col_q, col_d;
  logic [7:0]         color_q;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_data_q, out_data_d;
  logic [CELL_W-1:0]  mem [CELLS];
  logic [CELL_W-1:0]  rd_data_q;
  logic               we, re, pop;
  addr_t              wa, ra;
  logic [CELL_W-1:0]  wd;
  logic               out_free;
  logic               scroll_due;
  logic               is_text;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign scroll_due = (row_q == ROW_W'(ROWS));
  assign is_text    = (cur_q.kind == CMD_CHAR) || (cur_q.kind == CMD_NEWLINE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (cnt_q == LAST_ADDR) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (cmd_valid_i && out_free) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (is_text && scroll_due) state_d = ST_SCROLL;
        else if (cur_q.kind == CMD_READ) state_d = ST_READ;
        else state_d = ST_IDLE;
      end
      ST_SCROLL: begin
        if (cnt_q == MOVE_END) state_d = ST_ZERO;
      end
      ST_ZERO: begin
        if (cnt_q == LAST_ADDR) state_d = ST_EXEC;
      end
      ST_READ: state_d = ST_IDLE;
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    cnt_d       = cnt_q;
    cur_d       = cur_q;
    row_d       = row_q;
    col_d       = col_q;
    we          = 1'b0;
    re          = 1'b0;
    wa          = cnt_q;
    wd          = '0;
    ra          = ADDR_W'(cnt_q + ADDR_W'(COLUMNS));
    pop         = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    unique case (state_q)
      ST_CLEAR: begin
        we    = 1'b1;
        wd    = BLANK_CELL;
        cnt_d = (cnt_q == LAST_ADDR) ? '0 : cnt_q + 1'b1;
      end
      ST_IDLE: begin
        if (cmd_valid_i && out_free) begin
          pop   = 1'b1;
          cur_d = cmd_i;
          cnt_d = '0;
        end
      end
      ST_EXEC: begin
        if (!(is_text && scroll_due)) begin
          unique case (cur_q.kind)
            CMD_CHAR: begin
              we = 1'b1;
              wa = cell_addr(row_q, col_q);
              wd = {color_q, cur_q.cell_data[7:0]};
              if (col_q == COL_W'(COLUMNS - 1)) begin
                row_d = row_q + 1'b1;
                col_d = '0;
              end else begin
                col_d = col_q + 1'b1;
              end
            end
            CMD_NEWLINE: begin
              row_d = row_q + 1'b1;
              col_d = '0;
            end
            CMD_PUT: begin
              we = 1'b1;
              wa = cur_q.addr;
              wd = cur_q.cell_data;
            end
            CMD_READ: begin
              re = 1'b1;
              ra = cur_q.addr;
            end
            default: ;
          endcase
          if (cur_q.kind != CMD_READ) begin
            out_valid_d              = 1'b1;
            out_data_d.cell_value    = '0;
            out_data_d.cursor_row    = row_d;
            out_data_d.cursor_column = col_d;
          end
        end
      end
      ST_SCROLL: begin
        re = (cnt_q != MOVE_END);
        if (cnt_q != '0) begin
          we = 1'b1;
          wa = ADDR_W'(cnt_q - 1'b1);
          wd = rd_data_q;
        end
        cnt_d = (cnt_q == MOVE_END) ? cnt_q : cnt_q + 1'b1;
      end
      ST_ZERO: begin
        we    = 1'b1;
        wd    = '0;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LAST_ADDR) begin
          row_d = ROW_W'(ROWS - 1);
          cnt_d = '0;
        end
      end
      ST_READ: begin
        out_valid_d              = 1'b1;
        out_data_d.cell_value    = rd_data_q;
        out_data_d.cursor_row    = row_q;
        out_data_d.cursor_column = col_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= '0;
      row_q       <= '0;
      col_q       <= '0;
      color_q     <= TEXT_COLOR_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      row_q       <= row_d;
      col_q       <= col_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        color_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    out_data_q <= out_data_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_data_q <= mem[ra];
    end
  end

  assign bk_o.pop      = pop;
  assign bk_o.clearing = (state_q == ST_CLEAR);
  assign out_valid_o   = out_valid_q;
  assign out_data_o    = out_data_q;

endmodule

[src/text_mode_terminal_writer_unit.sv]
// input items are queued (two entries) and executed one at a time by the back end, which
// takes a new command only when idle and its output register is free; a put char with a
// scroll pending first moves the rows up one cell per cycle, then sets the last row to zero
// reset: cursor to row 0 column 0, text color 7, then a clearing pass sets
// every cell to 0x0720 while input is stalled; configuration writes are taken throughout
module text_mode_terminal_writer_unit import tmtw_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_item_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_item_t  out_data_o,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_data_i
);

  bk_ctl_t bk_ctl;
  logic    cmd_valid;
  cmd_t    cmd;

  tmtw_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .bk_i        (bk_ctl),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd)
  );

  tmtw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .bk_o        (bk_ctl),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
